// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/bsp_pkg.sv =====
package bsp_pkg;

  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MIN_SIZE   = 3;

  localparam int unsigned WIDTH_W    = 10;
  localparam int unsigned HEIGHT_W   = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 3);

  localparam int unsigned WIN_W   = 9;
  localparam int unsigned WIN_CTR = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  localparam int unsigned COND_N = 58;
  localparam int unsigned KEEP_N = 364;

  localparam logic [WIN_W-1:0] COND_PAT [COND_N] = '{
    9'o120, 9'o420, 9'o024, 9'o021, 9'o030, 9'o220,
    9'o060, 9'o022, 9'o130, 9'o320, 9'o620, 9'o460,
    9'o064, 9'o026, 9'o023, 9'o031, 9'o131, 9'o720,
    9'o464, 9'o027, 9'o630, 9'o231, 9'o360, 9'o132,
    9'o330, 9'o660, 9'o066, 9'o033, 9'o631, 9'o364,
    9'o730, 9'o331, 9'o760, 9'o664, 9'o466, 9'o067,
    9'o037, 9'o133, 9'o731, 9'o764, 9'o467, 9'o137,
    9'o333, 9'o770, 9'o666, 9'o077, 9'o733, 9'o337,
    9'o774, 9'o771, 9'o766, 9'o667, 9'o477, 9'o177, 9'o737, 9'o775, 9'o767, 9'o577
  };

  localparam logic [WIN_W-1:0] KEEP_PAT [KEEP_N] = '{
    9'o120, 9'o420, 9'o022, 9'o030, 9'o130, 9'o320, 9'o620, 9'o460, 9'o064,
    9'o026, 9'o023, 9'o031, 9'o360, 9'o630, 9'o231, 9'o132, 9'o134, 9'o324, 9'o334,
    9'o621, 9'o461, 9'o661, 9'o126, 9'o164, 9'o166, 9'o431, 9'o423, 9'o433,
    9'o660, 9'o661, 9'o670, 9'o671, 9'o760, 9'o761, 9'o770,
    9'o771, 9'o662, 9'o663, 9'o672, 9'o673, 9'o762, 9'o763,
    9'o772, 9'o773, 9'o664, 9'o665, 9'o674, 9'o675, 9'o764, 9'o765,
    9'o774, 9'o775, 9'o666, 9'o667, 9'o676, 9'o677, 9'o766, 9'o767, 9'o776, 9'o777,
    9'o262, 9'o362, 9'o662, 9'o762, 9'o262, 9'o263, 9'o266, 9'o267,
    9'o232, 9'o233, 9'o236, 9'o237, 9'o232, 9'o332, 9'o632, 9'o732,
    9'o270, 9'o274, 9'o670, 9'o674, 9'o270, 9'o271, 9'o370, 9'o371,
    9'o072, 9'o073, 9'o172, 9'o173, 9'o072, 9'o076, 9'o472, 9'o476,
    9'o425, 9'o434, 9'o435, 9'o524, 9'o525, 9'o534,
    9'o535, 9'o427, 9'o436, 9'o437, 9'o526, 9'o527,
    9'o536, 9'o537, 9'o625, 9'o634, 9'o635, 9'o724,
    9'o725, 9'o734, 9'o735, 9'o627, 9'o636, 9'o637,
    9'o726, 9'o727, 9'o736, 9'o737, 9'o465, 9'o474,
    9'o475, 9'o564, 9'o565, 9'o574, 9'o575, 9'o467,
    9'o476, 9'o477, 9'o566, 9'o567, 9'o576, 9'o577,
    9'o665, 9'o674, 9'o675, 9'o764, 9'o765, 9'o774,
    9'o775, 9'o667, 9'o676, 9'o677, 9'o766, 9'o767, 9'o776, 9'o777,
    9'o524, 9'o522, 9'o526, 9'o521, 9'o525, 9'o523,
    9'o527, 9'o534, 9'o532, 9'o536, 9'o531, 9'o535,
    9'o533, 9'o537, 9'o724, 9'o722, 9'o726, 9'o721,
    9'o725, 9'o723, 9'o727, 9'o734, 9'o732, 9'o736,
    9'o731, 9'o735, 9'o733, 9'o737, 9'o564, 9'o562,
    9'o566, 9'o561, 9'o565, 9'o563, 9'o567, 9'o574,
    9'o572, 9'o576, 9'o571, 9'o575, 9'o573, 9'o577,
    9'o764, 9'o762, 9'o766, 9'o761, 9'o765, 9'o763,
    9'o767, 9'o774, 9'o772, 9'o776, 9'o771, 9'o775, 9'o773, 9'o777,
    9'o125, 9'o161, 9'o165, 9'o521, 9'o525, 9'o561,
    9'o565, 9'o135, 9'o171, 9'o175, 9'o531, 9'o535,
    9'o571, 9'o575, 9'o127, 9'o163, 9'o167, 9'o523,
    9'o527, 9'o563, 9'o567, 9'o137, 9'o173, 9'o177,
    9'o533, 9'o537, 9'o573, 9'o577, 9'o325, 9'o361,
    9'o365, 9'o721, 9'o725, 9'o761, 9'o765, 9'o335,
    9'o371, 9'o375, 9'o731, 9'o735, 9'o771, 9'o775,
    9'o327, 9'o363, 9'o367, 9'o723, 9'o727, 9'o763,
    9'o767, 9'o337, 9'o373, 9'o377, 9'o733, 9'o737, 9'o773, 9'o777,
    9'o125, 9'o225, 9'o325, 9'o425, 9'o525, 9'o625,
    9'o725, 9'o135, 9'o235, 9'o335, 9'o435, 9'o535,
    9'o635, 9'o735, 9'o127, 9'o227, 9'o327, 9'o427,
    9'o527, 9'o627, 9'o727, 9'o137, 9'o237, 9'o337,
    9'o437, 9'o537, 9'o637, 9'o737, 9'o165, 9'o265,
    9'o365, 9'o465, 9'o565, 9'o665, 9'o765, 9'o175,
    9'o275, 9'o375, 9'o475, 9'o575, 9'o675, 9'o775,
    9'o167, 9'o267, 9'o367, 9'o467, 9'o567, 9'o667,
    9'o767, 9'o177, 9'o277, 9'o377, 9'o477, 9'o577, 9'o677, 9'o777,
    9'o162, 9'o163, 9'o562, 9'o563,
    9'o261, 9'o361, 9'o265, 9'o365, 9'o234, 9'o235, 9'o634, 9'o635,
    9'o432, 9'o532, 9'o436, 9'o536, 9'o660, 9'o661, 9'o670, 9'o671, 9'o760, 9'o761,
    9'o770, 9'o771, 9'o662, 9'o663, 9'o672, 9'o673,
    9'o762, 9'o763, 9'o772, 9'o773, 9'o664, 9'o665,
    9'o674, 9'o675, 9'o764, 9'o765, 9'o774, 9'o775,
    9'o666, 9'o667, 9'o676, 9'o677, 9'o766, 9'o767,
    9'o776, 9'o777
  };

  function automatic logic [2**WIN_W-1:0] build_cond_tab();
    logic [2**WIN_W-1:0] t;
    t = '0;
    for (int i = 0; i < COND_N; i++) begin
      t[COND_PAT[i]] = 1'b1;
    end
    return t;
  endfunction

  function automatic logic [2**WIN_W-1:0] build_keep_tab();
    logic [2**WIN_W-1:0] t;
    t = '0;
    for (int i = 0; i < KEEP_N; i++) begin
      t[KEEP_PAT[i]] = 1'b1;
    end
    return t;
  endfunction

  localparam logic [2**WIN_W-1:0] COND_TAB = build_cond_tab();
  localparam logic [2**WIN_W-1:0] KEEP_TAB = build_keep_tab();

  // Shifts a 3x3 window one column to the left and enters a new right-hand column.
  function automatic logic [WIN_W-1:0] win_shift(input logic [WIN_W-1:0] w, input logic top,
                                                 input logic mid, input logic bot);
    return {w[7], w[6], top, w[4], w[3], mid, w[1], w[0], bot};
  endfunction

  function automatic logic [WCNT_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
    int unsigned x;
    x = 32'(v);
    if (x < MIN_SIZE) begin
      x = MIN_SIZE;
    end else if (x > MAX_WIDTH) begin
      x = MAX_WIDTH;
    end
    return WCNT_W'(x);
  endfunction

  function automatic logic [ROW_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
    int unsigned x;
    x = 32'(v);
    if (x < MIN_SIZE) begin
      x = MIN_SIZE;
    end else if (x > MAX_HEIGHT) begin
      x = MAX_HEIGHT;
    end
    return ROW_W'(x);
  endfunction

endpackage

// ===== rtl/bsp_ram.sv =====
module bsp_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/binary_shrink_pass.sv =====
// One pass of two-stage 3x3 morphological shrinking on a binary frame streamed in raster
// order. The block takes one request per clock while the output side is not stalled and
// returns one registered result per request; the rate is set by two line buffers,
// each a single-port-pair RAM of MAX_WIDTH entries, read once and written once per pixel.
// The result for a frame pixel trails its input by 2*W+2 requests, so after the last pixel
// of a frame the host sends 2*W+2 drain requests; a drain request inside a frame returns an
// empty result and changes nothing. Border pixels come out as 0, and a pixel request after
// the frame has ended starts a new frame. Writing either size register restarts the frame;
// sizes are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
`include "assert_macros.svh"

module binary_shrink_pass (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_pixel,
  input  logic                           in_drain,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_shrunk_pixel,
  output logic                           out_out_valid,
  output logic                           out_frame_last,
  input  logic                           cfg_we,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bsp_pkg::*;

  typedef struct packed {
    logic             act;
    logic             pix;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] qc;
    logic             mint;
    logic             oval;
    logic             oint;
    logic             last;
  } s1_t;

  typedef struct packed {
    logic             act;
    logic             mark;
    logic             pixq;
    logic [COL_W-1:0] qc;
    logic             oval;
    logic             oint;
    logic             last;
  } s2_t;

  logic [WCNT_W-1:0] w_r;
  logic [ROW_W-1:0]  h_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              cfg_hit;

  logic              adv, in_acc;
  logic              past_frame, null_item, restart_px, row_end, last_pos;
  logic [ROW_W-1:0]  r_e;
  logic [COL_W-1:0]  c_e;

  s1_t               s1_r, s1_nxt;
  s2_t               s2_r, s2_nxt;
  logic              s1_v_r, s2_v_r;

  logic [1:0]        prd;
  logic [2:0]        mrd;
  logic              pix_we, mark_we;
  logic [WIN_W-1:0]  pwin_r, pwin_nxt;
  logic [WIN_W-1:0]  mwin_r, mwin_nxt;
  logic              opix_r;
  logic              shrunk;

  logic              out_valid_r, out_shrunk_r, out_ov_r, out_last_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_acc   = in_valid && adv;
  assign cfg_hit  = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_comb begin
    past_frame = row_r >= h_r;
    null_item  = in_drain && !past_frame;
    restart_px = !in_drain && past_frame;
    r_e        = restart_px ? '0 : row_r;
    c_e        = restart_px ? '0 : col_r;
    row_end    = (WCNT_W'(c_e) + WCNT_W'(1)) == w_r;
    last_pos   = (r_e == h_r + ROW_W'(2)) && (c_e == COL_W'(1));

    s1_nxt.act  = !null_item;
    s1_nxt.pix  = in_pixel;
    s1_nxt.col  = c_e;
    s1_nxt.qc   = (c_e == '0) ? COL_W'(w_r - WCNT_W'(1)) : c_e - COL_W'(1);
    s1_nxt.mint = (c_e >= COL_W'(2)) && (r_e >= ROW_W'(2)) && (r_e < h_r);
    s1_nxt.oval = (r_e > ROW_W'(2)) || ((r_e == ROW_W'(2)) && (c_e >= COL_W'(2)));
    s1_nxt.oint = ((c_e >= COL_W'(3)) && (r_e >= ROW_W'(3)) && (r_e <= h_r)) ||
                  ((c_e == '0) && (r_e >= ROW_W'(4)) && (r_e <= h_r + ROW_W'(1)));
    s1_nxt.last = last_pos;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc && !null_item) begin
      priority if (last_pos) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = r_e + ROW_W'(1);
      end else begin
        col_nxt = c_e + COL_W'(1);
        row_nxt = r_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= clamp_width(WIDTH_W'(480));
      h_r   <= clamp_height(HEIGHT_W'(480));
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        w_r <= clamp_width(cfg_data[WIDTH_W-1:0]);
      end else begin
        h_r <= clamp_height(cfg_data[HEIGHT_W-1:0]);
      end
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Pixel line buffer: bit 1 holds the row above, bit 0 the row above that.
  bsp_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (s1_r.col),
    .wdata ({s1_r.pix, prd[1]}),
    .re    (in_acc && !null_item),
    .raddr (c_e),
    .rdata (prd)
  );

  always_comb begin
    pix_we      = adv && s1_v_r && s1_r.act;
    pwin_nxt    = win_shift(pwin_r, prd[0], prd[1], s1_r.pix);
    s2_nxt.act  = s1_r.act;
    s2_nxt.mark = s1_r.mint && pwin_nxt[WIN_CTR] && COND_TAB[pwin_nxt];
    s2_nxt.pixq = pwin_nxt[WIN_CTR];
    s2_nxt.qc   = s1_r.qc;
    s2_nxt.oval = s1_r.oval;
    s2_nxt.oint = s1_r.oint;
    s2_nxt.last = s1_r.last;
  end

  // Mark line buffer: bit 2 holds the pixel of the row above, bit 1 its mark and bit 0 the
  // mark of the row above that.
  bsp_ram #(
    .WIDTH (3),
    .DEPTH (MAX_WIDTH)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (s2_r.qc),
    .wdata ({s2_r.pixq, s2_r.mark, mrd[1]}),
    .re    (pix_we),
    .raddr (s1_r.qc),
    .rdata (mrd)
  );

  always_comb begin
    mark_we  = adv && s2_v_r && s2_r.act;
    mwin_nxt = win_shift(mwin_r, mrd[0], mrd[1], s2_r.mark);
    shrunk   = s2_r.oint && opix_r && (!mwin_nxt[WIN_CTR] || KEEP_TAB[mwin_nxt]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_acc;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwin_r <= '0;
      mwin_r <= '0;
      opix_r <= 1'b0;
    end else begin
      if (pix_we) begin
        pwin_r <= pwin_nxt;
      end
      if (mark_we) begin
        mwin_r <= mwin_nxt;
        opix_r <= mrd[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r         <= s1_nxt;
      s2_r         <= s2_nxt;
      out_shrunk_r <= s2_r.act && shrunk;
      out_ov_r     <= s2_r.act && s2_r.oval;
      out_last_r   <= s2_r.act && s2_r.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_shrunk_pixel = out_shrunk_r;
  assign out_out_valid    = out_ov_r;
  assign out_frame_last   = out_last_r;

  `BSP_ASSERT_IMP(a_col_range, clk, rst_n, 1'b1, WCNT_W'(col_r) < w_r)
  `BSP_ASSERT_IMP(a_row_range, clk, rst_n, 1'b1, row_r <= h_r + ROW_W'(2))
  `BSP_ASSERT_IMP(a_field_valid, clk, rst_n, out_valid && (out_shrunk_pixel || out_frame_last), out_out_valid)
  `BSP_ASSERT_NXT(a_s2_to_out, clk, rst_n, s2_v_r && adv, out_valid)

endmodule
